### rtl/frsd_pkg.sv
// Shared types and constants of the frame-rate slowdown detector.
package frsd_pkg;

  localparam logic [47:0] T48_MAX        = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] GAP_US         = 48'd30000000;
  localparam logic [47:0] SEV_RECENT_US  = 48'd2000000;
  localparam logic [63:0] FPS_SCALE      = 64'd1000000000;
  localparam logic [30:0] FPS_MAX        = 31'h7FFF_FFFF;

  localparam logic [1:0] MODE_DISABLED  = 2'd0;
  localparam logic [1:0] MODE_ARMED     = 2'd1;
  localparam logic [1:0] MODE_CAPTURING = 2'd2;
  localparam logic [1:0] MODE_COOLDOWN  = 2'd3;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_WINLEN   = 3'd1;
  localparam logic [2:0] REG_SEVERE   = 3'd2;
  localparam logic [2:0] REG_SLOWPCT  = 3'd3;
  localparam logic [2:0] REG_ABSSLOW  = 3'd4;
  localparam logic [2:0] REG_CAPLEN   = 3'd5;
  localparam logic [2:0] REG_COOLLEN  = 3'd6;
  localparam logic [2:0] REG_SUPPLEN  = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // register the accepted word
    logic pre;        // apply gap, setting, tag and severe updates
    logic div_start;  // start the fps division and decide whether the window closes
    logic fin;        // finish window and mode update
  } frsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } frsd_sts_t;

endpackage

### rtl/frsd_div.sv
// Serial restoring divider, one quotient bit per cycle.
module frsd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [48:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    sh = {rem_r[47:0], q_r[63]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = sh - {1'b0, dvs_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != 7'd0);
  assign quotient = q_r;
endmodule

### rtl/frsd_ctrl.sv
// Sequencing controller of the frame-rate slowdown detector.
module frsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  frsd_pkg::frsd_sts_t sts,
  output frsd_pkg::frsd_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_PRE, S_START, S_WAIT, S_FIN, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.div_busy) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          cmd.fin = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
endmodule

### rtl/frsd_dp.sv
// Datapath of the frame-rate slowdown detector: state, window math and mode.
module frsd_dp #(
  parameter int SEVERE_HISTORY = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  frsd_pkg::frsd_cmd_t cmd,
  output frsd_pkg::frsd_sts_t sts,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [47:0] in_end_time_us,
  input  logic [30:0] in_total_time_us,
  input  logic [30:0] in_wait_time_us,
  input  logic [9:0]  in_max_fps,
  input  logic        in_vsync_on,
  input  logic [15:0] in_context_tag,
  output logic        out_window_closed,
  output logic        out_window_event,
  output logic        out_trigger_event,
  output logic        out_trigger_was_severe,
  output logic        out_capture_end_event,
  output logic [30:0] out_window_fps_milli,
  output logic [30:0] out_target_fps_milli,
  output logic [31:0] out_capture_count,
  output logic [1:0]  out_mode
);
  // Configuration registers.
  logic [31:0] winlen_r, sevthr_r, caplen_r, coollen_r, supplen_r;
  logic [6:0]  slowpct_r;
  logic [30:0] absslow_r;

  // Latched input word.
  logic [47:0] now_r;
  logic [30:0] busy_r;
  logic [9:0]  mfps_r;
  logic        vs_r;
  logic [15:0] tag_r;

  // Detector state.
  logic [1:0]  mode_r, mode_nxt;
  logic [47:0] last_r, last_nxt;
  logic [9:0]  smf_r, smf_nxt;
  logic        svs_r, svs_nxt;
  logic [15:0] stag_r, stag_nxt;
  logic        stv_r, stv_nxt;
  logic [47:0] supp_r, supp_nxt;
  logic [30:0] base_r, base_nxt;
  logic [1:0]  swc_r, swc_nxt;
  logic [47:0] sev_r [SEVERE_HISTORY];
  logic [47:0] sev_nxt [SEVERE_HISTORY];
  logic [47:0] ws_r, ws_nxt;
  logic [31:0] wf_r, wf_nxt;
  logic [30:0] lwf_r, lwf_nxt;
  logic [30:0] lwe_r, lwe_nxt;
  logic [31:0] cc_r, cc_nxt;
  logic [47:0] ce_r, ce_nxt;
  logic [47:0] cde_r, cde_nxt;
  logic        sflag_r, sflag_nxt;
  logic        close_r, close_nxt;
  logic        fin_o_r, wev_o_r, trg_o_r, cend_o_r;
  logic        fin_o_nxt, wev_o_nxt, trg_o_nxt, cend_o_nxt;

  logic        div_busy;
  logic [63:0] quot;
  logic [47:0] span;
  logic [47:0] need;

  function automatic logic [47:0] add48(input logic [47:0] t, input logic [31:0] len);
    logic [48:0] s;
    s = {1'b0, t} + {17'd0, len};
    return s[48] ? frsd_pkg::T48_MAX : s[47:0];
  endfunction

  assign span = now_r - ws_r;
  assign need = (winlen_r == 32'd0) ? 48'd1 : {16'd0, winlen_r};

  frsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({32'd0, wf_r} * frsd_pkg::FPS_SCALE),
    .divisor  (span),
    .busy     (div_busy),
    .quotient (quot)
  );
  assign sts.div_busy = div_busy;

  logic [30:0] fps;
  logic [30:0] expct;
  logic [40:0] fps100;
  logic [37:0] expsl;
  logic [19:0] cap1000;
  logic [47:0] s0;
  logic        sev_hit;
  logic [1:0]  md;
  logic [1:0]  swc_t;

  always_comb begin
    mode_nxt = mode_r; last_nxt = last_r; smf_nxt = smf_r; svs_nxt = svs_r;
    stag_nxt = stag_r; stv_nxt = stv_r; supp_nxt = supp_r; base_nxt = base_r;
    swc_nxt = swc_r; ws_nxt = ws_r; wf_nxt = wf_r; lwf_nxt = lwf_r;
    lwe_nxt = lwe_r; cc_nxt = cc_r; ce_nxt = ce_r; cde_nxt = cde_r;
    sflag_nxt = sflag_r; close_nxt = close_r;
    fin_o_nxt = fin_o_r; wev_o_nxt = wev_o_r; trg_o_nxt = trg_o_r;
    cend_o_nxt = cend_o_r;
    for (int i = 0; i < SEVERE_HISTORY; i++) sev_nxt[i] = sev_r[i];
    fps = (quot > {33'd0, frsd_pkg::FPS_MAX}) ? frsd_pkg::FPS_MAX : quot[30:0];
    cap1000 = smf_r * 10'd1000;
    expct = base_r;
    if (!svs_r && smf_r != 10'd0) begin
      if (expct == 31'd0 || expct > {11'd0, cap1000}) expct = {11'd0, cap1000};
    end
    fps100 = fps * 10'd100;
    expsl = expct * slowpct_r;
    s0 = sev_r[0];
    sev_hit = 1'b0;
    md = mode_r;
    swc_t = swc_r;

    if (cmd.pre) begin
      close_nxt = 1'b0;
      if (mode_r != frsd_pkg::MODE_DISABLED) begin
        if (last_r != 48'd0 && now_r >= last_r && now_r - last_r >= frsd_pkg::GAP_US) begin
          swc_nxt = 2'd0;
          for (int i = 0; i < SEVERE_HISTORY; i++) sev_nxt[i] = '0;
          ws_nxt = now_r;
          wf_nxt = '0;
        end
        last_nxt = now_r;
        if (mfps_r != smf_r || vs_r != svs_r) begin
          base_nxt = '0;
          swc_nxt = 2'd0;
          smf_nxt = mfps_r;
          svs_nxt = vs_r;
          supp_nxt = add48(now_r, supplen_r);
          for (int i = 0; i < SEVERE_HISTORY; i++) sev_nxt[i] = '0;
          ws_nxt = now_r;
          wf_nxt = '0;
        end
        if (!stv_r || tag_r != stag_r) begin
          stag_nxt = tag_r;
          stv_nxt = 1'b1;
          supp_nxt = add48(now_r, supplen_r);
          swc_nxt = 2'd0;
        end
        if ({1'b0, busy_r} >= sevthr_r) begin
          for (int i = 0; i + 1 < SEVERE_HISTORY; i++) sev_nxt[i] = sev_nxt[i + 1];
          sev_nxt[SEVERE_HISTORY - 1] = now_r;
        end
        if (ws_nxt == 48'd0) ws_nxt = now_r;
        if (wf_nxt != 32'hFFFF_FFFF) wf_nxt = wf_nxt + 32'd1;
      end
    end

    if (cmd.div_start) begin
      close_nxt = (mode_r != frsd_pkg::MODE_DISABLED) && now_r >= ws_r &&
                  wf_r != 32'd0 && span >= need;
    end

    // Event flags change only here, so a waiting result word stays intact.
    if (cmd.fin) begin
      fin_o_nxt = 1'b0; wev_o_nxt = 1'b0; trg_o_nxt = 1'b0; cend_o_nxt = 1'b0;
      if (mode_r != frsd_pkg::MODE_DISABLED) begin
        if (close_r) begin
          lwf_nxt = fps;
          lwe_nxt = expct;
          if ({1'b0, fps} < {1'b0, absslow_r}) swc_t = 2'd2;
          else if (expct != 31'd0 && {7'd0, fps100} < {10'd0, expsl}) begin
            if (swc_t != 2'd3) swc_t = swc_t + 2'd1;
          end else swc_t = 2'd0;
          if (fps > base_r) base_nxt = fps;
          ws_nxt = now_r;
          wf_nxt = '0;
        end
        fin_o_nxt = close_r;
        wev_o_nxt = close_r && mode_r == frsd_pkg::MODE_CAPTURING;
        if (mode_r == frsd_pkg::MODE_CAPTURING && now_r >= ce_r) begin
          md = frsd_pkg::MODE_COOLDOWN;
          cde_nxt = add48(now_r, coollen_r);
          cend_o_nxt = 1'b1;
        end else if (mode_r == frsd_pkg::MODE_COOLDOWN && now_r >= cde_r) begin
          md = frsd_pkg::MODE_ARMED;
          swc_t = 2'd0;
        end
        if (md == frsd_pkg::MODE_ARMED && now_r >= supp_r) begin
          sev_hit = s0 != 48'd0 &&
                    (now_r < s0 || now_r - s0 <= frsd_pkg::SEV_RECENT_US);
          if (swc_t >= 2'd2 || sev_hit) begin
            md = frsd_pkg::MODE_CAPTURING;
            cc_nxt = cc_r + 32'd1;
            ce_nxt = add48(now_r, caplen_r);
            sflag_nxt = (swc_t < 2'd2);
            swc_t = 2'd0;
            trg_o_nxt = 1'b1;
          end
        end
        mode_nxt = md;
        swc_nxt = swc_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= in_end_time_us;
      busy_r <= (in_total_time_us > in_wait_time_us) ?
                in_total_time_us - in_wait_time_us : 31'd0;
      mfps_r <= in_max_fps;
      vs_r   <= in_vsync_on;
      tag_r  <= in_context_tag;
    end
    if (!rst_n) begin
      winlen_r <= 32'd1000000;
      sevthr_r <= 32'd100000;
      slowpct_r <= 7'd70;
      absslow_r <= 31'd8000;
      caplen_r <= 32'd60000000;
      coollen_r <= 32'd300000000;
      supplen_r <= 32'd3000000;
    end else if (cfg_we) begin
      case (cfg_index)
        frsd_pkg::REG_WINLEN:  winlen_r <= cfg_wdata;
        frsd_pkg::REG_SEVERE:  sevthr_r <= cfg_wdata;
        frsd_pkg::REG_SLOWPCT: slowpct_r <= cfg_wdata[6:0];
        frsd_pkg::REG_ABSSLOW: absslow_r <= cfg_wdata[30:0];
        frsd_pkg::REG_CAPLEN:  caplen_r <= cfg_wdata;
        frsd_pkg::REG_COOLLEN: coollen_r <= cfg_wdata;
        frsd_pkg::REG_SUPPLEN: supplen_r <= cfg_wdata;
        default: ;
      endcase
    end
    if (!rst_n || (cfg_we && cfg_index == frsd_pkg::REG_ENABLE && !cfg_wdata[0])) begin
      mode_r <= frsd_pkg::MODE_DISABLED;
      last_r <= '0; smf_r <= '0; svs_r <= 1'b0; stag_r <= '0; stv_r <= 1'b0;
      supp_r <= '0; base_r <= '0; swc_r <= '0; ws_r <= '0; wf_r <= '0;
      lwf_r <= '0; lwe_r <= '0; cc_r <= '0; ce_r <= '0; cde_r <= '0;
      sflag_r <= 1'b0; close_r <= 1'b0;
      fin_o_r <= 1'b0; wev_o_r <= 1'b0; trg_o_r <= 1'b0; cend_o_r <= 1'b0;
      for (int i = 0; i < SEVERE_HISTORY; i++) sev_r[i] <= '0;
    end else begin
      mode_r <= (cfg_we && cfg_index == frsd_pkg::REG_ENABLE &&
                 mode_r == frsd_pkg::MODE_DISABLED) ? frsd_pkg::MODE_ARMED : mode_nxt;
      last_r <= last_nxt; smf_r <= smf_nxt; svs_r <= svs_nxt; stag_r <= stag_nxt;
      stv_r <= stv_nxt; supp_r <= supp_nxt; base_r <= base_nxt; swc_r <= swc_nxt;
      ws_r <= ws_nxt; wf_r <= wf_nxt; lwf_r <= lwf_nxt; lwe_r <= lwe_nxt;
      cc_r <= cc_nxt; ce_r <= ce_nxt; cde_r <= cde_nxt; sflag_r <= sflag_nxt;
      close_r <= close_nxt;
      fin_o_r <= fin_o_nxt; wev_o_r <= wev_o_nxt; trg_o_r <= trg_o_nxt;
      cend_o_r <= cend_o_nxt;
      for (int i = 0; i < SEVERE_HISTORY; i++) sev_r[i] <= sev_nxt[i];
    end
  end

  // Result fields hold steady after the word is produced until the next one.
  assign out_window_closed      = fin_o_r;
  assign out_window_event       = wev_o_r;
  assign out_trigger_event      = trg_o_r;
  assign out_trigger_was_severe = sflag_r;
  assign out_capture_end_event  = cend_o_r;
  assign out_window_fps_milli   = lwf_r;
  assign out_target_fps_milli   = lwe_r;
  assign out_capture_count      = cc_r;
  assign out_mode               = mode_r;
endmodule

### rtl/frame_rate_slowdown_detector.sv
// Frame-rate slowdown detector: one result word per frame word, one word at a time.
// From input acceptance to out_valid the word passes through load, state update, divider
// start, 64 serial divider steps, a check that the divider is idle, and the final step.
// No new word is taken until the last is done; a stalled result delays only the final step.
// Reset (rst_n low, synchronous) clears all detector state, restores register defaults and
// leaves the detector disabled; clearing enable returns the state to reset too.
module frame_rate_slowdown_detector #(
  parameter int SEVERE_HISTORY = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_end_time_us,
  input  logic [30:0] in_total_time_us,
  input  logic [30:0] in_wait_time_us,
  input  logic [9:0]  in_max_fps,
  input  logic        in_vsync_on,
  input  logic [15:0] in_context_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_window_closed,
  output logic        out_window_event,
  output logic        out_trigger_event,
  output logic        out_trigger_was_severe,
  output logic        out_capture_end_event,
  output logic [30:0] out_window_fps_milli,
  output logic [30:0] out_target_fps_milli,
  output logic [31:0] out_capture_count,
  output logic [1:0]  out_mode
);
  frsd_pkg::frsd_cmd_t cmd;
  frsd_pkg::frsd_sts_t sts;

  // The controller sequences load, state update, division and the final step.
  frsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds all detector state and the divider.
  frsd_dp #(.SEVERE_HISTORY(SEVERE_HISTORY)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_end_time_us         (in_end_time_us),
    .in_total_time_us       (in_total_time_us),
    .in_wait_time_us        (in_wait_time_us),
    .in_max_fps             (in_max_fps),
    .in_vsync_on            (in_vsync_on),
    .in_context_tag         (in_context_tag),
    .out_window_closed      (out_window_closed),
    .out_window_event       (out_window_event),
    .out_trigger_event      (out_trigger_event),
    .out_trigger_was_severe (out_trigger_was_severe),
    .out_capture_end_event  (out_capture_end_event),
    .out_window_fps_milli   (out_window_fps_milli),
    .out_target_fps_milli   (out_target_fps_milli),
    .out_capture_count      (out_capture_count),
    .out_mode               (out_mode)
  );
endmodule
